@@ rtl/core/csu_pkg.sv @@
// Package for the counting semaphore unit: transaction structs, codes, defaults.
// No dependencies.
`default_nettype none
package csu_pkg;
	localparam int SEM_SLOTS_DEF    = 16;
	localparam int WAIT_DEPTH_DEF   = 8;
	localparam int PROC_ID_BITS_DEF = 8;
	localparam int COUNT_BITS_DEF   = 16;

	localparam logic [2:0] OP_CREATE  = 3'd0;
	localparam logic [2:0] OP_DESTROY = 3'd1;
	localparam logic [2:0] OP_TRYWAIT = 3'd2;
	localparam logic [2:0] OP_POST    = 3'd3;
	localparam logic [2:0] OP_WAIT    = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BLOCK    = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_NOSLOT   = 3'd3;
	localparam logic [2:0] ST_QFULL    = 3'd4;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] sem_handle;
		logic [7:0]  process_id;
	} csu_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] handle_out;
		logic        wake_valid;
		logic [7:0]  wake_process;
		logic        wake_ok;
		logic        blocked;
		logic        last;
	} csu_res_t;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_DRD, S_DOUT, S_FIN, S_POUT
	} csu_state_t;
endpackage
`default_nettype wire

@@ rtl/core/counting_semaphore_unit_top.sv @@
// Counting semaphore table with per-slot FIFO wait queues.
// Create, try_wait, wait, not-found, post without release and destroy with an empty queue
// finish in S_EXEC; a post that releases a waiter adds S_POUT, a destroy with queued waiters
// adds S_DRD and S_DOUT per waiter, then S_FIN. The slot metadata RAM read-modify-write
// sets the rate; busy covers the whole transaction.
// Results are strobed on done, receiver never stalls.
// Reset clears control state and slot valid bits; RAMs need no clearing.
// Depends on csu_pkg.
`default_nettype none
module counting_semaphore_unit_top #(
	parameter int SEM_SLOTS    = csu_pkg::SEM_SLOTS_DEF,
	parameter int WAIT_DEPTH   = csu_pkg::WAIT_DEPTH_DEF,
	parameter int PROC_ID_BITS = csu_pkg::PROC_ID_BITS_DEF,
	parameter int COUNT_BITS   = csu_pkg::COUNT_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  csu_pkg::csu_cmd_t cmd,
	output logic              busy,
	output logic              done,
	output csu_pkg::csu_res_t result
);
	import csu_pkg::*;

	localparam int SW = $clog2(SEM_SLOTS);
	localparam int PW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int FW = $clog2(WAIT_DEPTH + 1);
	localparam int MW = COUNT_BITS + 2 * PW + FW;
	localparam logic [PW-1:0] PTR_LAST = PW'(WAIT_DEPTH - 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(WAIT_DEPTH);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	csu_state_t state_q, state_nxt;

	logic [SEM_SLOTS-1:0] in_use_q;
	logic [31:0]          handle_q [SEM_SLOTS];
	logic [31:0]          hcnt_q;

	logic [MW-1:0]           meta_mem [SEM_SLOTS];
	logic [MW-1:0]           meta_rd_q;
	logic [PROC_ID_BITS-1:0] wait_mem [SEM_SLOTS * (2 ** PW)];
	logic [PROC_ID_BITS-1:0] wait_rd_q;

	logic [2:0]              op_s1;
	logic [SW-1:0]           slot_s1;
	logic                    hit_s1;
	logic [PROC_ID_BITS-1:0] pid_s1;
	logic [PW-1:0]           head_q;
	logic [FW-1:0]           fill_q;

	logic          accept;
	logic [SW-1:0] hit_idx, free_idx;
	logic          hit, free_any;
	logic [PROC_ID_BITS-1:0] pid_in;
	logic [7:0]    wake_pid;

	logic [COUNT_BITS-1:0] m_cnt, cnt_inc;
	logic [PW-1:0]         m_head, m_tail, head_inc, tail_inc;
	logic [FW-1:0]         m_fill;

	logic          meta_we;
	logic [MW-1:0] meta_wd;
	logic          wq_we, wq_re;
	logic [SW+PW-1:0] wq_waddr, wq_raddr;
	logic          res_v;
	csu_res_t      res_d;
	logic          create_ok, free_slot, post_pop;

	assign accept = start && !busy;
	assign {m_cnt, m_head, m_tail, m_fill} = meta_rd_q;
	assign cnt_inc  = (m_cnt == CNT_MAX) ? m_cnt : m_cnt + 1'b1;
	assign head_inc = (m_head == PTR_LAST) ? '0 : m_head + 1'b1;
	assign tail_inc = (m_tail == PTR_LAST) ? '0 : m_tail + 1'b1;
	assign post_pop = (cnt_inc != '0) && (m_fill != '0);

	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SEM_SLOTS - 1; i >= 0; i--) begin
			if (in_use_q[i] && handle_q[i] == cmd.sem_handle) begin
				hit = 1'b1;
				hit_idx = SW'(i);
			end
			if (!in_use_q[i]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	always_comb begin
		pid_in = '0;
		wake_pid = '0;
		for (int b = 0; b < PROC_ID_BITS; b++)
			if (b < 8) pid_in[b] = cmd.process_id[b];
		for (int b = 0; b < 8; b++)
			if (b < PROC_ID_BITS) wake_pid[b] = wait_rd_q[b];
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: if (accept) state_nxt = S_EXEC;
			S_EXEC: begin
				state_nxt = S_IDLE;
				if (hit_s1 && op_s1 == OP_DESTROY && m_fill != '0) state_nxt = S_DRD;
				if (hit_s1 && op_s1 == OP_POST && post_pop) state_nxt = S_POUT;
			end
			S_DRD:  state_nxt = S_DOUT;
			S_DOUT: state_nxt = (fill_q == '0) ? S_FIN : S_DRD;
			S_FIN:  state_nxt = S_IDLE;
			S_POUT: state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		res_v = 1'b0;
		res_d = '0;
		meta_we = 1'b0;
		meta_wd = meta_rd_q;
		wq_we = 1'b0;
		wq_re = 1'b0;
		wq_waddr = {slot_s1, m_tail};
		wq_raddr = {slot_s1, m_head};
		create_ok = 1'b0;
		free_slot = 1'b0;
		case (state_q)
			S_EXEC: begin
				res_v = 1'b1;
				res_d.last = 1'b1;
				if (op_s1 == OP_CREATE) begin
					if (hit_s1) begin
						create_ok = 1'b1;
						res_d.handle_out = hcnt_q + 1'b1;
						meta_we = 1'b1;
						meta_wd = '0;
					end else begin
						res_d.status = ST_NOSLOT;
					end
				end else if (op_s1 > OP_WAIT) begin
					res_d.status = ST_OK;
				end else if (!hit_s1) begin
					res_d.status = ST_NOTFOUND;
				end else begin
					case (op_s1)
						OP_DESTROY: begin
							if (m_fill != '0) res_v = 1'b0;
							else free_slot = 1'b1;
						end
						OP_TRYWAIT: begin
							if (m_cnt != '0) begin
								meta_we = 1'b1;
								meta_wd = {m_cnt - 1'b1, m_head, m_tail, m_fill};
							end else begin
								res_d.status = ST_BLOCK;
							end
						end
						OP_POST: begin
							meta_we = 1'b1;
							if (post_pop) begin
								res_v = 1'b0;
								wq_re = 1'b1;
								meta_wd = {cnt_inc - 1'b1, head_inc, m_tail, m_fill - 1'b1};
							end else begin
								meta_wd = {cnt_inc, m_head, m_tail, m_fill};
							end
						end
						OP_WAIT: begin
							if (m_cnt != '0) begin
								meta_we = 1'b1;
								meta_wd = {m_cnt - 1'b1, m_head, m_tail, m_fill};
							end else if (m_fill >= FILL_MAX) begin
								res_d.status = ST_QFULL;
							end else begin
								meta_we = 1'b1;
								meta_wd = {m_cnt, m_head, tail_inc, m_fill + 1'b1};
								wq_we = 1'b1;
								res_d.blocked = 1'b1;
							end
						end
						default: res_d.status = ST_OK;
					endcase
				end
			end
			S_DRD: begin
				wq_re = 1'b1;
				wq_raddr = {slot_s1, head_q};
			end
			S_DOUT, S_POUT: begin
				res_v = 1'b1;
				res_d.wake_valid = 1'b1;
				res_d.wake_process = wake_pid;
				res_d.wake_ok = (state_q == S_POUT);
				res_d.last = (state_q == S_POUT);
			end
			S_FIN: begin
				res_v = 1'b1;
				res_d.last = 1'b1;
				free_slot = 1'b1;
			end
			default: res_v = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			in_use_q <= '0;
			hcnt_q   <= '0;
			done     <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done    <= res_v;
			if (create_ok) begin
				in_use_q[slot_s1] <= 1'b1;
				hcnt_q <= hcnt_q + 1'b1;
			end
			if (free_slot) in_use_q[slot_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_d;
		if (create_ok) handle_q[slot_s1] <= hcnt_q + 1'b1;
		if (accept) begin
			op_s1   <= cmd.opcode;
			pid_s1  <= pid_in;
			slot_s1 <= (cmd.opcode == OP_CREATE) ? free_idx : hit_idx;
			hit_s1  <= (cmd.opcode == OP_CREATE) ? free_any : hit;
		end
		if (state_q == S_EXEC) begin
			head_q <= m_head;
			fill_q <= m_fill;
		end else if (state_q == S_DRD) begin
			head_q <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
			fill_q <= fill_q - 1'b1;
		end
	end

	// slot metadata RAM
	always_ff @(posedge clk) begin
		if (meta_we) meta_mem[slot_s1] <= meta_wd;
		if (accept) meta_rd_q <= meta_mem[(cmd.opcode == OP_CREATE) ? free_idx : hit_idx];
	end

	// waiter RAM
	always_ff @(posedge clk) begin
		if (wq_we) wait_mem[wq_waddr] <= pid_s1;
		if (wq_re) wait_rd_q <= wait_mem[wq_raddr];
	end

	assign busy = (state_q != S_IDLE);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("busy not raised after accept");
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last |-> busy) else $error("non-final result while idle");
	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.wake_ok |-> result.wake_valid) else $error("wake_ok without wake");
	a_no_done_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !done) else $error("result before execution");
endmodule
`default_nettype wire

@@ test/counting_semaphore_unit_top_test.sv @@
// Testbench for counting_semaphore_unit_top: drives semaphore commands with random idling and
// checks every strobed result against a behavioral semaphore table kept in a scoreboard class.
// Depends on csu_pkg and the counting_semaphore_unit_top RTL.
`default_nettype none
module counting_semaphore_unit_top_test;
	import csu_pkg::*;

	localparam int SLOTS     = SEM_SLOTS_DEF;
	localparam int QDEPTH    = WAIT_DEPTH_DEF;
	localparam int CNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
	localparam int IDLE_LIMIT = 4000;

	class sem_table_sb;
		logic [31:0] next_handle;
		bit          used [SLOTS];
		logic [31:0] handle [SLOTS];
		int          count [SLOTS];
		logic [7:0]  waiters [SLOTS][$];
		csu_res_t    pending [$];
		int          errors;

		function void clear();
			next_handle = 0;
			errors = 0;
			for (int i = 0; i < SLOTS; i++) begin
				used[i] = 0;
				waiters[i].delete();
			end
			pending.delete();
		endfunction

		function int lookup(logic [31:0] h);
			for (int i = 0; i < SLOTS; i++)
				if (used[i] && handle[i] == h) return i;
			return -1;
		endfunction

		function csu_res_t mk(logic [2:0] st, logic [31:0] h, bit wv, logic [7:0] wp,
				bit wok, bit blk, bit lst);
			csu_res_t r;
			r.status = st; r.handle_out = h; r.wake_valid = wv; r.wake_process = wp;
			r.wake_ok = wok; r.blocked = blk; r.last = lst;
			return r;
		endfunction

		function void note_command(csu_cmd_t c);
			int s;
			int n;
			if (c.opcode == OP_CREATE) begin
				s = -1;
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!used[i]) s = i;
				if (s < 0) begin
					pending.push_back(mk(ST_NOSLOT, 0, 0, 0, 0, 0, 1));
					return;
				end
				next_handle++;
				used[s] = 1; handle[s] = next_handle; count[s] = 0;
				waiters[s].delete();
				pending.push_back(mk(ST_OK, next_handle, 0, 0, 0, 0, 1));
				return;
			end
			if (c.opcode > OP_WAIT) begin
				pending.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
				return;
			end
			s = lookup(c.sem_handle);
			if (s < 0) begin
				pending.push_back(mk(ST_NOTFOUND, 0, 0, 0, 0, 0, 1));
				return;
			end
			case (c.opcode)
				OP_DESTROY: begin
					while (waiters[s].size() > 0)
						pending.push_back(mk(ST_OK, 0, 1, waiters[s].pop_front(), 0, 0, 0));
					used[s] = 0;
					pending.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
				end
				OP_TRYWAIT: begin
					if (count[s] > 0) begin
						count[s]--;
						pending.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
					end else
						pending.push_back(mk(ST_BLOCK, 0, 0, 0, 0, 0, 1));
				end
				OP_POST: begin
					n = 0;
					if (count[s] < CNT_MAX) count[s]++;
					while (count[s] > 0 && waiters[s].size() > 0) begin
						count[s]--;
						pending.push_back(mk(ST_OK, 0, 1, waiters[s].pop_front(), 1, 0, 0));
						n++;
					end
					if (n == 0) pending.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
					else pending[$].last = 1;
				end
				default: begin
					if (count[s] > 0) begin
						count[s]--;
						pending.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
					end else if (waiters[s].size() >= QDEPTH)
						pending.push_back(mk(ST_QFULL, 0, 0, 0, 0, 0, 1));
					else begin
						waiters[s].push_back(c.process_id);
						pending.push_back(mk(ST_OK, 0, 0, 0, 0, 1, 1));
					end
				end
			endcase
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(csu_res_t r);
			csu_res_t e;
			if (pending.size() == 0) begin
				report("unexpected result", 32'(r), 32'd0);
				return;
			end
			e = pending.pop_front();
			if (r.status != e.status) report("status", 32'(r.status), 32'(e.status));
			if (r.handle_out != e.handle_out) report("handle_out", r.handle_out, e.handle_out);
			if (r.wake_valid != e.wake_valid)
				report("wake_valid", 32'(r.wake_valid), 32'(e.wake_valid));
			if (r.wake_process != e.wake_process)
				report("wake_process", 32'(r.wake_process), 32'(e.wake_process));
			if (r.wake_ok != e.wake_ok) report("wake_ok", 32'(r.wake_ok), 32'(e.wake_ok));
			if (r.blocked != e.blocked) report("blocked", 32'(r.blocked), 32'(e.blocked));
			if (r.last != e.last) report("last", 32'(r.last), 32'(e.last));
		endtask
	endclass

	logic     clk = 0;
	logic     arst_n = 0;
	logic     start = 0;
	csu_cmd_t cmd = '0;
	logic     busy;
	logic     done;
	csu_res_t result;

	sem_table_sb sems = new();
	int          send_idle_pct = 33;
	int          idle_cycles = 0;
	logic [31:0] live [$];

	counting_semaphore_unit_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .result(result)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		if (done) sems.check_result(result);
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task send(logic [2:0] op, logic [31:0] h, logic [7:0] pid);
		csu_cmd_t c;
		c.opcode = op; c.sem_handle = h; c.process_id = pid;
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		start <= 1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		sems.note_command(c);
		if (op == OP_CREATE && sems.pending[$].status == ST_OK)
			live.push_back(sems.pending[$].handle_out);
		start <= 0;
		cmd <= '0;
		@(posedge clk);
	endtask

	task drain();
		while (sems.pending.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function logic [31:0] pick_handle();
		if (live.size() > 0 && $urandom_range(9) < 8)
			return live[$urandom_range(live.size() - 1)];
		return $urandom();
	endfunction

	task random_phase(int n);
		int r;
		logic [31:0] h;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			h = pick_handle();
			if (r < 12) send(OP_CREATE, $urandom(), 8'($urandom()));
			else if (r < 20) send(OP_DESTROY, h, 8'($urandom()));
			else if (r < 35) send(OP_TRYWAIT, h, 8'($urandom()));
			else if (r < 60) send(OP_POST, h, 8'($urandom()));
			else if (r < 95) send(OP_WAIT, h, 8'($urandom()));
			else send(3'($urandom_range(7)), h, 8'($urandom()));
		end
	endtask

	initial begin
		logic [31:0] h0;
		sems.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: queue full, release order, destroy drain, not found
		send(OP_TRYWAIT, 32'h0, 8'h00);
		send(OP_CREATE, 32'hFFFF_FFFF, 8'hFF);
		h0 = live[0];
		send(OP_TRYWAIT, h0, 8'h00);
		for (int i = 0; i < QDEPTH; i++) send(OP_WAIT, h0, 8'(i * 37 + 1));
		send(OP_WAIT, h0, 8'hFF);
		send(OP_POST, h0, 8'h00);
		send(OP_POST, h0, 8'h00);
		send(OP_DESTROY, h0, 8'h00);
		send(OP_POST, h0, 8'h00);
		send(3'd5, 32'hFFFF_FFFF, 8'hFF);
		send(3'd7, 32'h0, 8'h00);
		send(3'd6, 32'h5A5A_A5A5, 8'h55);
		drain();
		for (int i = 0; i < SLOTS + 1; i++) send(OP_CREATE, 32'h0, 8'h00);
		send(OP_POST, live[1], 8'h00);
		send(OP_TRYWAIT, live[1], 8'h00);
		send(OP_TRYWAIT, live[1], 8'h00);
		drain();
		// raise one count, then free everything
		for (int i = 0; i < 6; i++) send(OP_POST, live[2], 8'h00);
		drain();
		for (int i = 1; i < live.size(); i++) send(OP_DESTROY, live[i], 8'h00);
		live.delete();
		drain();

		send_idle_pct = 33;
		random_phase(66);
		drain();
		send_idle_pct = 55;
		random_phase(66);
		drain();
		send_idle_pct = 0;
		random_phase(66);
		drain();

		if (sems.errors == 0 && sems.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/csu_pkg.sv
rtl/core/counting_semaphore_unit_top.sv
test/counting_semaphore_unit_top_test.sv
